[sv/cos_pkg.sv]
// Package for the circular overwrite stack: request/response payload types,
// action codes and fixed widths. No dependencies.
package cos_pkg;

	// Element width and config register width
	localparam int DATA_WIDTH = 32;
	localparam int CAP_WIDTH  = 7;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

	// Action codes carried in a request
	typedef enum logic [2:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_GET    = 3'd2,
		ACT_REWIND = 3'd3,
		ACT_CLEAR  = 3'd4,
		ACT_REMOVE = 3'd5
	} cos_action_t;

	// Request payload
	typedef struct packed {
		logic [2:0]            action;
		logic [DATA_WIDTH-1:0] push_value;
	} cos_req_t;

	// Response payload
	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_value;
		logic                  status;
	} cos_rsp_t;

	// Per-request control from the pointer unit to the response stage
	typedef struct packed {
		logic use_data;
		logic fail;
	} cos_op_ctl_t;

endpackage

[sv/cos_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No package dependencies.
module cos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on we, otherwise read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[sv/cos_ctrl.sv]
// Pointer and count unit of the circular overwrite stack: holds the
// capacity register, top/bottom/cursor pointers and counts, issues RAM access.
// Depends on cos_pkg.
module cos_ctrl #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cos_pkg::CAP_WIDTH-1:0]    cfg_wdata,
	input  logic                             acc,
	input  cos_pkg::cos_req_t                req,
	output logic                             mem_en,
	output logic                             mem_we,
	output logic [$clog2(MAX_DEPTH)-1:0]     mem_addr,
	output cos_pkg::cos_op_ctl_t             op_ctl
);
	import cos_pkg::*;

	localparam int PW  = $clog2(MAX_DEPTH);
	localparam int CW  = $clog2(MAX_DEPTH + 1);
	localparam int XW  = ((CW > CAP_WIDTH) ? CW : CAP_WIDTH) + 1;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_DEPTH);

	logic [CAP_WIDTH-1:0] cap_q;
	logic [PW-1:0]        top_q, bottom_q, cursor_q;
	logic [CW-1:0]        held_q, rdcnt_q;

	logic [PW-1:0]        top_d, bottom_d, cursor_d;
	logic [CW-1:0]        held_d, rdcnt_d;
	logic [XW-1:0]        cap_x, eff;
	logic [XW-1:0]        held_inc;
	logic [PW-1:0]        top_up, top_dn, cur_dn, bot_up;

	// Advance a pointer, wrapping at the effective capacity
	function automatic logic [PW-1:0] step_up(logic [PW-1:0] p, logic [XW-1:0] e);
		logic [XW-1:0] px;
		px = XW'(p) + XW'(1);
		return (px >= e) ? '0 : PW'(px);
	endfunction

	// Step a pointer back, wrapping from slot 0 to the last slot
	function automatic logic [PW-1:0] step_down(logic [PW-1:0] p, logic [XW-1:0] e);
		logic [XW-1:0] em;
		em = e - XW'(1);
		return (p == '0) ? PW'(em) : p - PW'(1);
	endfunction

	// Clamp the capacity register into 1..MAX_DEPTH
	always_comb begin
		cap_x = XW'(cap_q);
		if (cap_x == '0) begin
			eff = XW'(1);
		end else if (cap_x > MAX_X) begin
			eff = MAX_X;
		end else begin
			eff = cap_x;
		end
	end

	assign top_up   = step_up(top_q, eff);
	assign top_dn   = step_down(top_q, eff);
	assign cur_dn   = step_down(cursor_q, eff);
	assign bot_up   = step_up(bottom_q, eff);
	assign held_inc = XW'(held_q) + XW'(1);

	// Decode the request: next pointers, counts and RAM access
	always_comb begin
		top_d    = top_q;
		bottom_d = bottom_q;
		cursor_d = cursor_q;
		held_d   = held_q;
		rdcnt_d  = rdcnt_q;
		mem_en   = 1'b0;
		mem_we   = 1'b0;
		mem_addr = top_q;
		op_ctl   = '0;
		unique case (req.action)
			ACT_PUSH: begin
				mem_en   = acc;
				mem_we   = 1'b1;
				mem_addr = top_q;
				top_d    = top_up;
				cursor_d = top_up;
				rdcnt_d  = '0;
				if (held_inc > eff) begin
					bottom_d = top_up;
					held_d   = CW'(eff);
				end else begin
					held_d   = CW'(held_inc);
				end
			end
			ACT_POP: begin
				if (held_q == '0) begin
					op_ctl.fail = 1'b1;
				end else begin
					mem_en          = acc;
					mem_addr        = top_dn;
					op_ctl.use_data = 1'b1;
					top_d           = top_dn;
					held_d          = held_q - CW'(1);
					if (top_q == cursor_q) begin
						cursor_d = top_dn;
					end else if (rdcnt_q != '0) begin
						rdcnt_d = rdcnt_q - CW'(1);
					end
				end
			end
			ACT_GET: begin
				if (rdcnt_q >= held_q) begin
					op_ctl.fail = 1'b1;
				end else begin
					mem_en          = acc;
					mem_addr        = cur_dn;
					op_ctl.use_data = 1'b1;
					cursor_d        = cur_dn;
					rdcnt_d         = rdcnt_q + CW'(1);
				end
			end
			ACT_REWIND: begin
				cursor_d = top_q;
				rdcnt_d  = '0;
			end
			ACT_CLEAR: begin
				top_d    = '0;
				bottom_d = '0;
				cursor_d = '0;
				held_d   = '0;
				rdcnt_d  = '0;
			end
			ACT_REMOVE: begin
				if (held_q == '0) begin
					op_ctl.fail = 1'b1;
				end else begin
					mem_en          = acc;
					mem_addr        = bottom_q;
					op_ctl.use_data = 1'b1;
					bottom_d        = bot_up;
					held_d          = held_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Hold capacity; advance pointers and counts on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			top_q    <= '0;
			bottom_q <= '0;
			cursor_q <= '0;
			held_q   <= '0;
			rdcnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc) begin
				top_q    <= top_d;
				bottom_q <= bottom_d;
				cursor_q <= cursor_d;
				held_q   <= held_d;
				rdcnt_q  <= rdcnt_d;
			end
		end
	end

endmodule

[sv/circular_overwrite_stack_top.sv]
// Top level of the circular overwrite stack: request handshake, RAM read
// stage and response register. Depends on cos_pkg, cos_ctrl and cos_ram.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_req  (cos_req_t)
//   out       output     out_valid / out_stall  out_rsp (cos_rsp_t)
//   cfg       input      cfg_we                 cfg_wdata (capacity)
//
// One request per cycle sustained while the response side is not stalled:
// pointers update when a request is taken, the single RAM port reads or
// writes in that same cycle, and the response then passes from the RAM read
// stage into the response register. Reset clears pointers and counts and sets
// capacity to 64; slot contents stay undefined until pushed. A stalled
// response holds the RAM read stage, which in turn stalls the request side.
module circular_overwrite_stack_top #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cos_pkg::cos_req_t             in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cos_pkg::cos_rsp_t             out_rsp,
	input  logic                          cfg_we,
	input  logic [cos_pkg::CAP_WIDTH-1:0] cfg_wdata
);
	import cos_pkg::*;

	localparam int PW = $clog2(MAX_DEPTH);

	logic                  acc;
	logic                  mem_en, mem_we;
	logic [PW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_rdata;
	cos_op_ctl_t           op_ctl;

	logic                  valid_s1;
	cos_op_ctl_t           ctl_s1;
	logic                  done_s1;
	logic                  out_valid_q;
	cos_rsp_t              out_q;

	// Accept when the read stage is empty or draining
	assign done_s1  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~done_s1;
	assign acc      = in_valid & ~in_stall;

	cos_ctrl #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.req       (in_req),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.op_ctl    (op_ctl)
	);

	cos_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_slots (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (in_req.push_value),
		.rdata (mem_rdata)
	);

	// Advance the read stage and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold request control and response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= op_ctl;
		end
		if (done_s1) begin
			out_q.read_value <= ctl_s1.use_data ? mem_rdata : '0;
			out_q.status     <= ctl_s1.fail;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

endmodule
